### hw/rtl/assert_macros.svh
// Assertion helpers, sampled on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/poct_pkg.sv
package poct_pkg;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] first_index;
        logic [3:0] second_index;
        logic [2:0] relation_in;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] relation_out;
        logic [4:0] element_total;
    } rsp_t;

    localparam int MAX_ELEMENTS_DEF = 16;
    localparam int TABLE_DEPTH_DEF  = 120;
    localparam int ELT_W            = 5;

    localparam logic [2:0] REL_UNK  = 3'd0;
    localparam logic [2:0] REL_GT   = 3'd1;
    localparam logic [2:0] REL_EQ   = 3'd2;
    localparam logic [2:0] REL_LT   = 3'd3;
    localparam logic [2:0] REL_NGEQ = 3'd4;
    localparam logic [2:0] REL_NLEQ = 3'd5;
    localparam logic [2:0] REL_INC  = 3'd6;
    localparam logic [2:0] REL_BAD  = 3'd7;

    localparam logic [1:0] OP_ASSERT = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_CHANGED  = 2'd0;
    localparam logic [1:0] ST_SAME     = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    localparam logic [1:0] KIND_STRICT = 2'd0;
    localparam logic [1:0] KIND_WEAK   = 2'd1;
    localparam logic [1:0] KIND_EQUAL  = 2'd2;

    function automatic logic [2:0] rev_rel(input logic [2:0] r);
        case (r)
            REL_GT:   return REL_LT;
            REL_LT:   return REL_GT;
            REL_NGEQ: return REL_NLEQ;
            REL_NLEQ: return REL_NGEQ;
            default:  return r;
        endcase
    endfunction

    // {ok, merged}
    function automatic logic [3:0] merge_rel(input logic [2:0] old, input logic [2:0] cur);
        if (old == REL_UNK)
        begin
            return {1'b1, cur};
        end
        case (cur)
            REL_GT:  return {(old inside {REL_GT, REL_NLEQ}), cur};
            REL_EQ:  return {(old == REL_EQ), cur};
            REL_LT:  return {(old inside {REL_LT, REL_NGEQ}), cur};
            REL_INC: return {(old inside {REL_INC, REL_NGEQ, REL_NLEQ}), cur};
            REL_NGEQ:
            begin
                if (old inside {REL_LT, REL_INC, REL_NGEQ})
                begin
                    return {1'b1, old};
                end
                else if (old == REL_NLEQ)
                begin
                    return {1'b1, REL_INC};
                end
                return {1'b0, cur};
            end
            REL_NLEQ:
            begin
                if (old inside {REL_GT, REL_INC, REL_NLEQ})
                begin
                    return {1'b1, old};
                end
                else if (old == REL_NGEQ)
                begin
                    return {1'b1, REL_INC};
                end
                return {1'b0, cur};
            end
            default: return {1'b1, old};
        endcase
    endfunction

    function automatic logic [2:0] eq_combine(input logic [2:0] rz, input logic [2:0] ru);
        case (rz)
            REL_EQ: return ru;
            REL_GT:
            begin
                if (ru inside {REL_EQ, REL_GT}) return REL_GT;
                if (ru inside {REL_NLEQ, REL_INC}) return REL_NLEQ;
                return REL_UNK;
            end
            REL_LT:
            begin
                if (ru inside {REL_EQ, REL_LT}) return REL_LT;
                if (ru inside {REL_NGEQ, REL_INC}) return REL_NGEQ;
                return REL_UNK;
            end
            REL_INC:
            begin
                if (ru == REL_GT) return REL_NLEQ;
                if (ru == REL_EQ) return REL_INC;
                if (ru == REL_LT) return REL_NGEQ;
                return REL_UNK;
            end
            REL_NGEQ: return (ru inside {REL_EQ, REL_LT}) ? REL_NGEQ : REL_UNK;
            REL_NLEQ: return (ru inside {REL_GT, REL_EQ}) ? REL_NLEQ : REL_UNK;
            default:  return REL_UNK;
        endcase
    endfunction

    // {update, value} for one neighbor found while scanning
    function automatic logic [3:0] scan_pick(input logic [1:0] kind, input logic [2:0] rel,
                                             input logic [2:0] wkn, input logic [2:0] r);
        case (kind)
            KIND_STRICT:
            begin
                if (r == rel || r == REL_EQ) return {1'b1, rel};
                if (r == wkn || r == REL_INC) return {1'b1, wkn};
                return {1'b0, REL_UNK};
            end
            KIND_WEAK:
            begin
                if (r == rel || r == REL_EQ) return {1'b1, wkn};
                return {1'b0, REL_UNK};
            end
            KIND_EQUAL: return {(r != REL_UNK), r};
            default:    return {1'b0, REL_UNK};
        endcase
    endfunction

    function automatic logic [2:0] pair_pick(input logic [1:0] kind, input logic [2:0] rel,
                                             input logic [2:0] wkn, input logic any_b,
                                             input logic [2:0] a, input logic [2:0] b);
        case (kind)
            KIND_STRICT:
            begin
                if (a == rel && b == rel) return rel;
                if (a == rel && b == wkn) return wkn;
                if (a == wkn && b == rel) return wkn;
                return REL_UNK;
            end
            KIND_WEAK:  return (a == wkn && b == wkn) ? wkn : REL_UNK;
            KIND_EQUAL:
            begin
                if (any_b && a != REL_UNK && b != REL_UNK) return eq_combine(a, b);
                return REL_UNK;
            end
            default:    return REL_UNK;
        endcase
    endfunction

endpackage

### hw/rtl/poct_ram.sv
module poct_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 120
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/poct_engine.sv
module poct_engine import poct_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic ready,
    output logic res_valid,
    input  logic res_take,
    output rsp_t res
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int EW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (2 * EW + 1 > SW + 1) ? 2 * EW + 1 : SW + 1;
    localparam int WW = (EW > 4) ? EW : 4;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_ADD  = 4'd2;
    localparam logic [3:0] S_COPY = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_EV   = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_PAIR = 4'd7;
    localparam logic [3:0] S_REST = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam logic [2:0] STEP_MAIN   = 3'd0;
    localparam logic [2:0] STEP_SA_GET = 3'd1;
    localparam logic [2:0] STEP_SA_PUT = 3'd2;
    localparam logic [2:0] STEP_SB_GET = 3'd3;
    localparam logic [2:0] STEP_SB_PUT = 3'd4;
    localparam logic [2:0] STEP_PAIR   = 3'd5;
    localparam logic [2:0] STEP_FINAL  = 3'd6;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    step_reg, step_next;
    logic          init_reg, init_next;
    logic [EW-1:0] count_reg, count_next;
    logic [EW-1:0] x_reg, x_next, y_reg, y_next;
    logic [EW-1:0] px_reg, px_next, py_reg, py_next;
    logic [2:0]    pv_reg, pv_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [EW-1:0] z_reg, z_next, u_reg, u_next;
    logic [EW-1:0] acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic [2:0]    acc_v_reg, acc_v_next;
    logic          acc_put_reg, acc_put_next;
    logic [1:0]    kind_reg, kind_next;
    logic [2:0]    rel_reg, rel_next, wkn_reg, wkn_next;
    logic          second_reg, second_next;
    logic          any_b_reg, any_b_next;
    logic [2:0]    amark_reg [MAX_ELEMENTS];
    logic [2:0]    amark_next [MAX_ELEMENTS];
    logic [2:0]    bmark_reg [MAX_ELEMENTS];
    logic [2:0]    bmark_next [MAX_ELEMENTS];
    logic [1:0]    status_reg, status_next;
    logic [2:0]    rout_reg, rout_next;

    logic          same, swapped;
    logic [EW-1:0] acc_lo, acc_hi, tri_lo, tri_hi;
    logic [XW-1:0] tri_prod, idx_full;
    logic          in_range;
    logic [AW-1:0] idx;
    logic [2:0]    main_rdata, shadow_rdata, raw, got, put_v;
    logic [3:0]    mres, sp;
    logic [2:0]    pp;
    logic          put_ok, put_chg;
    logic          main_we, shadow_we;
    logic [AW-1:0] main_waddr, main_raddr, shadow_waddr, shadow_raddr;
    logic [2:0]    main_wdata;
    logic [AW-1:0] cnt_addr, cnt_prev_addr;
    logic          bad_index;

    poct_ram #(.WIDTH(3), .DEPTH(TABLE_DEPTH)) u_main (
        .clk   (clk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    poct_ram #(.WIDTH(3), .DEPTH(TABLE_DEPTH)) u_shadow (
        .clk   (clk),
        .we    (shadow_we),
        .waddr (shadow_waddr),
        .wdata (main_rdata),
        .raddr (shadow_raddr),
        .rdata (shadow_rdata)
    );

    assign same    = (acc_a_reg == acc_b_reg);
    assign swapped = (acc_a_reg > acc_b_reg);
    assign acc_lo  = swapped ? acc_b_reg : acc_a_reg;
    assign acc_hi  = swapped ? acc_a_reg : acc_b_reg;
    assign tri_lo  = (state_reg == S_ADD) ? z_reg : acc_lo;
    assign tri_hi  = (state_reg == S_ADD) ? count_reg : acc_hi;

    assign tri_prod = XW'(tri_hi) * XW'(tri_hi - EW'(1));
    assign idx_full = (tri_prod >> 1) + XW'(tri_lo);
    assign in_range = (idx_full < XW'(TABLE_DEPTH));
    assign idx      = AW'(idx_full);

    assign raw     = in_range ? main_rdata : REL_UNK;
    assign got     = same ? REL_EQ : (swapped ? rev_rel(raw) : raw);
    assign put_v   = swapped ? rev_rel(acc_v_reg) : acc_v_reg;
    assign mres    = merge_rel(raw, put_v);
    assign put_ok  = same || !in_range || mres[3];
    assign put_chg = !same && in_range && mres[3] && (mres[2:0] != raw);
    assign sp      = scan_pick(kind_reg, rel_reg, wkn_reg, got);
    assign pp      = pair_pick(kind_reg, rel_reg, wkn_reg, any_b_reg,
                               amark_reg[z_reg[IW-1:0]], bmark_reg[u_reg[IW-1:0]]);

    assign cnt_addr      = (cnt_reg < SW'(TABLE_DEPTH)) ? AW'(cnt_reg) : '0;
    assign cnt_prev_addr = AW'(cnt_reg - SW'(1));

    assign bad_index = (WW'(req.first_index) >= WW'(count_reg))
                    || (WW'(req.second_index) >= WW'(count_reg));

    always_comb
    begin
        main_we      = 1'b0;
        main_waddr   = idx;
        main_wdata   = REL_UNK;
        main_raddr   = idx;
        shadow_we    = 1'b0;
        shadow_waddr = cnt_prev_addr;
        shadow_raddr = cnt_addr;
        case (state_reg)
            S_CLR:
            begin
                main_we    = 1'b1;
                main_waddr = cnt_addr;
            end
            S_ADD:
            begin
                main_we = (z_reg < count_reg) && in_range;
            end
            S_COPY:
            begin
                main_raddr = cnt_addr;
                shadow_we  = (cnt_reg != '0);
            end
            S_EV:
            begin
                main_we    = acc_put_reg && put_chg;
                main_wdata = mres[2:0];
            end
            S_REST:
            begin
                main_we    = (cnt_reg != '0);
                main_waddr = cnt_prev_addr;
                main_wdata = shadow_rdata;
            end
            default:
            begin
                main_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        init_next    = init_reg;
        count_next   = count_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pv_next      = pv_reg;
        cnt_next     = cnt_reg;
        z_next       = z_reg;
        u_next       = u_reg;
        acc_a_next   = acc_a_reg;
        acc_b_next   = acc_b_reg;
        acc_v_next   = acc_v_reg;
        acc_put_next = acc_put_reg;
        kind_next    = kind_reg;
        rel_next     = rel_reg;
        wkn_next     = wkn_reg;
        second_next  = second_reg;
        any_b_next   = any_b_reg;
        amark_next   = amark_reg;
        bmark_next   = bmark_reg;
        status_next  = status_reg;
        rout_next    = rout_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_next    = EW'(req.first_index);
                    y_next    = EW'(req.second_index);
                    rout_next = REL_UNK;
                    cnt_next  = '0;
                    z_next    = '0;
                    if (req.opcode == OP_CLEAR)
                    begin
                        status_next = ST_CHANGED;
                        state_next  = S_CLR;
                    end
                    else if (req.opcode == OP_ADD)
                    begin
                        if (count_reg >= EW'(MAX_ELEMENTS))
                        begin
                            status_next = ST_BAD;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            status_next = ST_CHANGED;
                            state_next  = S_ADD;
                        end
                    end
                    else if (bad_index)
                    begin
                        status_next = ST_BAD;
                        state_next  = S_DONE;
                    end
                    else if (req.opcode == OP_QUERY || req.first_index == req.second_index
                             || req.relation_in == REL_UNK || req.relation_in == REL_BAD)
                    begin
                        status_next  = ST_SAME;
                        acc_a_next   = EW'(req.first_index);
                        acc_b_next   = EW'(req.second_index);
                        acc_put_next = 1'b0;
                        step_next    = STEP_FINAL;
                        state_next   = S_RD;
                    end
                    else
                    begin
                        if (req.first_index > req.second_index)
                        begin
                            px_next = EW'(req.second_index);
                            py_next = EW'(req.first_index);
                            pv_next = rev_rel(req.relation_in);
                        end
                        else
                        begin
                            px_next = EW'(req.first_index);
                            py_next = EW'(req.second_index);
                            pv_next = req.relation_in;
                        end
                        state_next = S_COPY;
                    end
                end
            end

            S_CLR:
            begin
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(TABLE_DEPTH - 1))
                begin
                    count_next = '0;
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_DONE;
                end
            end

            S_ADD:
            begin
                if (z_reg >= count_reg)
                begin
                    count_next = count_reg + EW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    z_next = z_reg + EW'(1);
                end
            end

            S_COPY:
            begin
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(TABLE_DEPTH))
                begin
                    acc_a_next   = px_reg;
                    acc_b_next   = py_reg;
                    acc_v_next   = pv_reg;
                    acc_put_next = 1'b1;
                    step_next    = STEP_MAIN;
                    state_next   = S_RD;
                end
            end

            S_RD:
            begin
                state_next = S_EV;
            end

            S_EV:
            begin
                state_next = S_RD;
                case (step_reg)
                    STEP_MAIN:
                    begin
                        if (!put_ok || !put_chg)
                        begin
                            status_next  = put_ok ? ST_SAME : ST_CONFLICT;
                            acc_a_next   = x_reg;
                            acc_b_next   = y_reg;
                            acc_put_next = 1'b0;
                            step_next    = STEP_FINAL;
                        end
                        else
                        begin
                            second_next = 1'b0;
                            case (pv_reg)
                                REL_GT, REL_LT:
                                begin
                                    kind_next = KIND_STRICT;
                                    rel_next  = pv_reg;
                                    wkn_next  = (pv_reg == REL_GT) ? REL_NLEQ : REL_NGEQ;
                                end
                                REL_EQ:
                                begin
                                    kind_next = KIND_EQUAL;
                                end
                                REL_NLEQ:
                                begin
                                    kind_next = KIND_WEAK;
                                    rel_next  = REL_GT;
                                    wkn_next  = REL_NLEQ;
                                end
                                REL_INC:
                                begin
                                    kind_next   = KIND_WEAK;
                                    rel_next    = REL_LT;
                                    wkn_next    = REL_NGEQ;
                                    second_next = 1'b1;
                                end
                                default:
                                begin
                                    kind_next = KIND_WEAK;
                                    rel_next  = REL_LT;
                                    wkn_next  = REL_NGEQ;
                                end
                            endcase
                            for (int i = 0; i < MAX_ELEMENTS; i++)
                            begin
                                amark_next[i] = REL_UNK;
                                bmark_next[i] = REL_UNK;
                            end
                            any_b_next = 1'b0;
                            z_next     = '0;
                            state_next = S_SCAN;
                        end
                    end
                    STEP_SA_GET:
                    begin
                        acc_put_next = sp[3];
                        if (sp[3])
                        begin
                            acc_a_next = z_reg;
                            acc_b_next = py_reg;
                            acc_v_next = sp[2:0];
                            step_next  = STEP_SA_PUT;
                        end
                        else
                        begin
                            acc_a_next = py_reg;
                            acc_b_next = z_reg;
                            step_next  = STEP_SB_GET;
                        end
                    end
                    STEP_SA_PUT:
                    begin
                        if (!put_ok)
                        begin
                            cnt_next   = '0;
                            state_next = S_REST;
                        end
                        else
                        begin
                            if (put_chg)
                            begin
                                amark_next[z_reg[IW-1:0]] = acc_v_reg;
                            end
                            acc_a_next   = py_reg;
                            acc_b_next   = z_reg;
                            acc_put_next = 1'b0;
                            step_next    = STEP_SB_GET;
                        end
                    end
                    STEP_SB_GET:
                    begin
                        acc_put_next = sp[3];
                        if (sp[3])
                        begin
                            acc_a_next = px_reg;
                            acc_b_next = z_reg;
                            acc_v_next = sp[2:0];
                            step_next  = STEP_SB_PUT;
                        end
                        else
                        begin
                            z_next     = z_reg + EW'(1);
                            state_next = S_SCAN;
                        end
                    end
                    STEP_SB_PUT:
                    begin
                        if (!put_ok)
                        begin
                            cnt_next   = '0;
                            state_next = S_REST;
                        end
                        else
                        begin
                            if (put_chg)
                            begin
                                bmark_next[z_reg[IW-1:0]] = acc_v_reg;
                                any_b_next = 1'b1;
                            end
                            z_next     = z_reg + EW'(1);
                            state_next = S_SCAN;
                        end
                    end
                    STEP_PAIR:
                    begin
                        if (!put_ok)
                        begin
                            cnt_next   = '0;
                            state_next = S_REST;
                        end
                        else
                        begin
                            u_next     = u_reg + EW'(1);
                            state_next = S_PAIR;
                        end
                    end
                    default:
                    begin
                        rout_next  = got;
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (z_reg >= count_reg)
                begin
                    z_next     = '0;
                    u_next     = '0;
                    state_next = S_PAIR;
                end
                else if (z_reg == px_reg || z_reg == py_reg)
                begin
                    z_next = z_reg + EW'(1);
                end
                else
                begin
                    acc_a_next   = z_reg;
                    acc_b_next   = px_reg;
                    acc_put_next = 1'b0;
                    step_next    = STEP_SA_GET;
                    state_next   = S_RD;
                end
            end

            S_PAIR:
            begin
                if (z_reg >= count_reg)
                begin
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        rel_next    = REL_GT;
                        wkn_next    = REL_NLEQ;
                        for (int i = 0; i < MAX_ELEMENTS; i++)
                        begin
                            amark_next[i] = REL_UNK;
                            bmark_next[i] = REL_UNK;
                        end
                        any_b_next = 1'b0;
                        z_next     = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        status_next  = ST_CHANGED;
                        acc_a_next   = x_reg;
                        acc_b_next   = y_reg;
                        acc_put_next = 1'b0;
                        step_next    = STEP_FINAL;
                        state_next   = S_RD;
                    end
                end
                else if (u_reg >= count_reg)
                begin
                    z_next = z_reg + EW'(1);
                    u_next = '0;
                end
                else if (z_reg != u_reg && pp != REL_UNK)
                begin
                    acc_a_next   = z_reg;
                    acc_b_next   = u_reg;
                    acc_v_next   = pp;
                    acc_put_next = 1'b1;
                    step_next    = STEP_PAIR;
                    state_next   = S_RD;
                end
                else
                begin
                    u_next = u_reg + EW'(1);
                end
            end

            S_REST:
            begin
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(TABLE_DEPTH))
                begin
                    status_next  = ST_CONFLICT;
                    acc_a_next   = x_reg;
                    acc_b_next   = y_reg;
                    acc_put_next = 1'b0;
                    step_next    = STEP_FINAL;
                    state_next   = S_RD;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            init_reg   <= 1'b1;
            cnt_reg    <= '0;
            count_reg  <= '0;
            step_reg   <= STEP_FINAL;
            second_reg <= 1'b0;
            any_b_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            init_reg   <= init_next;
            cnt_reg    <= cnt_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            second_reg <= second_next;
            any_b_reg  <= any_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pv_reg      <= pv_next;
        z_reg       <= z_next;
        u_reg       <= u_next;
        acc_a_reg   <= acc_a_next;
        acc_b_reg   <= acc_b_next;
        acc_v_reg   <= acc_v_next;
        acc_put_reg <= acc_put_next;
        kind_reg    <= kind_next;
        rel_reg     <= rel_next;
        wkn_reg     <= wkn_next;
        amark_reg   <= amark_next;
        bmark_reg   <= bmark_next;
        status_reg  <= status_next;
        rout_reg    <= rout_next;
    end

    assign ready               = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_DONE);
    assign res.status          = status_reg;
    assign res.relation_out    = rout_reg;
    assign res.element_total   = ELT_W'(count_reg);

endmodule

### hw/rtl/partial_order_closure_table_top.sv
// Channel | Valid     | Stall     | Payload
// req     | req_valid | req_stall | req (opcode, indices, relation)
// rsp     | rsp_valid | rsp_stall | rsp (status, relation, total)
//
// After reset the table is zeroed before the first item is taken.
// An assertion first copies the table into a shadow table, then each table read
// or update passes through a read state and an evaluate state: up to 4 accesses
// per element in the scan and one per derived pair when pairing.
// A conflict restores the table from the shadow table. rsp_stall holds the
// output register, and a finished result waits in the engine while that
// register is full and stalled; the next item is taken while a result waits
// in the output register.
`include "assert_macros.svh"

module partial_order_closure_table_top import poct_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic eng_ready;
    logic eng_start;
    logic eng_res_valid;
    logic eng_take;
    rsp_t eng_res;
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    assign req_stall = !eng_ready;
    assign eng_start = req_valid && eng_ready;
    assign eng_take  = eng_res_valid && (!rsp_valid_reg || !rsp_stall);

    poct_engine #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .req       (req),
        .ready     (eng_ready),
        .res_valid (eng_res_valid),
        .res_take  (eng_take),
        .res       (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (eng_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_take)
        begin
            rsp_reg <= eng_res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "item taken while busy")
    `ASSERT_NOW(a_bad_no_rel, rsp_valid && rsp.status == ST_BAD, rsp.relation_out == REL_UNK, "relation on rejected item")

endmodule
